/* rtl/sdm_pkg.sv */
package sdm_pkg;

  // Fixed field widths of the ports
  localparam int DIVISOR_W = 32;
  localparam int MULT_W    = 32;
  localparam int SHIFT_W   = 5;

  // Default internal arithmetic width
  localparam int DEF_WIDTH = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REM,
    ST_ANC,
    ST_DIV1,
    ST_DIV2,
    ST_LOOP1,
    ST_LOOP2,
    ST_CHECK,
    ST_FINAL
  } sdm_state_e;

  // Sequencer controls towards the datapath
  typedef struct packed {
    logic idle;      // ready for a new divisor
    logic load;      // divisor transfer this cycle
    logic step_en;   // shared divide step writes back
    logic use_2;     // step works on q2/r2 rather than q1/r1
    logic div_anc;   // step divides by anc rather than |d|
    logic shift_in;  // feed dividend bit from quotient MSB
    logic anc_en;    // form anc from t mod |d|
    logic final_en;  // write the result register
  } sdm_ctrl_t;

endpackage

/* rtl/sdm_div_step.sv */
module sdm_div_step #(
  parameter int WIDTH = sdm_pkg::DEF_WIDTH
) (
  input  logic [WIDTH-1:0] rem_i,
  input  logic [WIDTH-1:0] quo_i,
  input  logic [WIDTH-1:0] div_i,
  input  logic             shift_in_i,
  output logic [WIDTH-1:0] rem_o,
  output logic [WIDTH-1:0] quo_o
);
  import sdm_pkg::*;

  logic [WIDTH:0] ext;
  logic [WIDTH:0] diff;
  logic           ge;

  // one restoring step: shift in a dividend bit (or zero), trial subtract
  always_comb begin
    ext   = {rem_i, shift_in_i & quo_i[WIDTH-1]};
    diff  = ext - {1'b0, div_i};
    ge    = ~diff[WIDTH];
    rem_o = ge ? diff[WIDTH-1:0] : ext[WIDTH-1:0];
    quo_o = {quo_i[WIDTH-2:0], ge};
  end

endmodule

/* rtl/sdm_fsm.sv */
module sdm_fsm #(
  parameter int WIDTH = sdm_pkg::DEF_WIDTH,
  parameter int IW    = $clog2(2 * WIDTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               ad_small_i,
  input  logic               loop_more_i,
  input  logic               out_free_i,
  output sdm_pkg::sdm_ctrl_t ctrl_o,
  output logic [IW-1:0]      iter_o
);
  import sdm_pkg::*;

  localparam int CW = $clog2(WIDTH);
  localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 1);
  localparam logic [IW-1:0] ITER_MAX = IW'(2 * WIDTH);

  sdm_state_e    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] iter_q, iter_d;
  logic          cnt_last;

  assign cnt_last = (cnt_q == CNT_LAST);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ad_small_i ? ST_FINAL : ST_REM;
      ST_REM:   if (cnt_last) state_d = ST_ANC;
      ST_ANC:   state_d = ST_DIV1;
      ST_DIV1:  if (cnt_last) state_d = ST_DIV2;
      ST_DIV2:  if (cnt_last) state_d = ST_LOOP1;
      ST_LOOP1: state_d = ST_LOOP2;
      ST_LOOP2: state_d = ST_CHECK;
      ST_CHECK: state_d = (loop_more_i && (iter_q < ITER_MAX)) ? ST_LOOP1 : ST_FINAL;
      ST_FINAL: if (out_free_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // counters
  always_comb begin
    cnt_d  = '0;
    iter_d = iter_q;
    if ((state_q == ST_REM) || (state_q == ST_DIV1) || (state_q == ST_DIV2)) begin
      cnt_d = cnt_last ? '0 : cnt_q + 1'b1;
    end
    if (state_q == ST_IDLE) begin
      iter_d = '0;
    end else if (state_q == ST_LOOP1) begin
      iter_d = iter_q + 1'b1;
    end
  end

  // outputs
  always_comb begin
    ctrl_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        ctrl_o.idle = 1'b1;
        ctrl_o.load = in_valid_i;
      end
      ST_REM: begin
        ctrl_o.step_en  = 1'b1;
        ctrl_o.shift_in = 1'b1;
      end
      ST_ANC:  ctrl_o.anc_en = 1'b1;
      ST_DIV1: begin
        ctrl_o.step_en  = 1'b1;
        ctrl_o.div_anc  = 1'b1;
        ctrl_o.shift_in = 1'b1;
      end
      ST_DIV2: begin
        ctrl_o.step_en  = 1'b1;
        ctrl_o.use_2    = 1'b1;
        ctrl_o.shift_in = 1'b1;
      end
      ST_LOOP1: begin
        ctrl_o.step_en = 1'b1;
        ctrl_o.div_anc = 1'b1;
      end
      ST_LOOP2: begin
        ctrl_o.step_en = 1'b1;
        ctrl_o.use_2   = 1'b1;
      end
      ST_CHECK: ctrl_o = '0;
      ST_FINAL: ctrl_o.final_en = out_free_i;
      default:  ctrl_o = '0;
    endcase
  end

  assign iter_o = iter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      iter_q  <= iter_d;
    end
  end

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_q <= ITER_MAX)
    else $error("doubling loop ran past its bound");

  a_cnt_only_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_REM && state_q != ST_DIV1 && state_q != ST_DIV2) |-> cnt_q == '0)
    else $error("step counter live outside a division phase");

endmodule

/* rtl/signed_div_magic_number.sv */
// Channel  | Handshake                 | Payload
// ---------+---------------------------+--------------------------------------------------
// in       | in_valid_i / in_ready_o   | divisor_i
// out      | out_valid_o / out_ready_i | multiplier_o shift_amt_o add_fix_o sub_fix_o invalid_o
//
// Sequence: divide steps for t mod |d|, a state to form anc, divide steps for 2^(W-1)/anc
//   and for 2^(W-1)/|d|, then doubling iterations (states LOOP1, LOOP2, CHECK), then the
//   finish state; all divide steps run on the single shared divide-step unit.
// A divisor of magnitude below two goes straight to the finish state.
// One divisor at a time: in_ready_o is high only while the sequencer is idle.
// The result register frees the sequencer; a stalled output holds the finish state.
// Reset (rst_ni, async, active low) clears sequencer and output valid only.
module signed_div_magic_number #(
  parameter int WIDTH = sdm_pkg::DEF_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [sdm_pkg::DIVISOR_W-1:0] divisor_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [sdm_pkg::MULT_W-1:0]    multiplier_o,
  output logic [sdm_pkg::SHIFT_W-1:0]          shift_amt_o,
  output logic                                add_fix_o,
  output logic                                sub_fix_o,
  output logic                                invalid_o
);
  import sdm_pkg::*;

  localparam int IW = $clog2(2 * WIDTH + 1);
  localparam int EW = (WIDTH > DIVISOR_W) ? WIDTH : DIVISOR_W;
  localparam int MW = (WIDTH > MULT_W) ? WIDTH : MULT_W;
  localparam logic [WIDTH-1:0] TWO = {1'b1, {(WIDTH-1){1'b0}}};
  localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

  sdm_ctrl_t      ctrl;
  logic [IW-1:0]  iter;

  // input decode: sign-extend then cut to WIDTH
  logic [EW-1:0]    div_ext;
  logic [WIDTH-1:0] d_in, ad_in;
  logic             dneg_in, ad_small;

  always_comb begin
    div_ext  = EW'(divisor_i);
    d_in     = div_ext[WIDTH-1:0];
    dneg_in  = d_in[WIDTH-1];
    ad_in    = dneg_in ? (~d_in + ONE) : d_in;
    ad_small = (ad_in[WIDTH-1:1] == '0);
  end

  // working registers
  logic [WIDTH-1:0] ad_q, anc_q, q1_q, r1_q, q2_q, r2_q;
  logic             dneg_q, inv_q;
  logic [WIDTH-1:0] ad_d, anc_d, q1_d, r1_d, q2_d, r2_d;
  logic             dneg_d, inv_d;

  // shared divide step
  logic [WIDTH-1:0] st_rem, st_quo, st_div, st_rem_n, st_quo_n;

  assign st_rem = ctrl.use_2 ? r2_q : r1_q;
  assign st_quo = ctrl.use_2 ? q2_q : q1_q;
  assign st_div = ctrl.div_anc ? anc_q : ad_q;

  sdm_div_step #(.WIDTH(WIDTH)) u_step (
    .rem_i      (st_rem),
    .quo_i      (st_quo),
    .div_i      (st_div),
    .shift_in_i (ctrl.shift_in),
    .rem_o      (st_rem_n),
    .quo_o      (st_quo_n)
  );

  // anc = t - 1 - (t mod |d|), with t = 2^(W-1) + dneg; -1 - r is ~r
  logic [WIDTH-1:0] anc_raw;
  assign anc_raw = (TWO | WIDTH'(dneg_q)) + ~r1_q;

  // loop continue test: q1 < delta, or equal with r1 zero
  logic [WIDTH-1:0] delta;
  logic             loop_more;
  assign delta     = ad_q - r2_q;
  assign loop_more = (q1_q < delta) || ((q1_q == delta) && (r1_q == '0));

  always_comb begin
    ad_d   = ad_q;
    anc_d  = anc_q;
    q1_d   = q1_q;
    r1_d   = r1_q;
    q2_d   = q2_q;
    r2_d   = r2_q;
    dneg_d = dneg_q;
    inv_d  = inv_q;
    if (ctrl.load) begin
      ad_d   = ad_in;
      dneg_d = dneg_in;
      inv_d  = ad_small;
      q1_d   = TWO | WIDTH'(dneg_in);   // dividend t for the remainder pass
      r1_d   = '0;
      q2_d   = TWO;
      r2_d   = '0;
    end else if (ctrl.anc_en) begin
      anc_d = (anc_raw == '0) ? ONE : anc_raw;
      q1_d  = TWO;
      r1_d  = '0;
    end else if (ctrl.step_en) begin
      if (ctrl.use_2) begin
        q2_d = st_quo_n;
        r2_d = st_rem_n;
      end else begin
        q1_d = st_quo_n;
        r1_d = st_rem_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ad_q   <= ad_d;
    anc_q  <= anc_d;
    q1_q   <= q1_d;
    r1_q   <= r1_d;
    q2_q   <= q2_d;
    r2_q   <= r2_d;
    dneg_q <= dneg_d;
    inv_q  <= inv_d;
  end

  // result register
  logic             out_valid_q, out_valid_d, out_free;
  logic [WIDTH-1:0] m;
  logic [MW-1:0]    m_ext;
  logic [IW-1:0]    shift_full;
  logic [MULT_W-1:0]  mult_q, mult_d;
  logic [SHIFT_W-1:0] shift_q, shift_d;
  logic             add_q, add_d, sub_q, sub_d, inv_out_q, inv_out_d;

  assign out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    // -(q2 + 1) is ~q2
    m          = dneg_q ? ~q2_q : q2_q + ONE;
    m_ext      = MW'(m);
    shift_full = iter - IW'(1);
    mult_d     = mult_q;
    shift_d    = shift_q;
    add_d      = add_q;
    sub_d      = sub_q;
    inv_out_d  = inv_out_q;
    if (ctrl.final_en) begin
      if (inv_q) begin
        mult_d    = '0;
        shift_d   = '0;
        add_d     = 1'b0;
        sub_d     = 1'b0;
        inv_out_d = 1'b1;
      end else begin
        mult_d    = m_ext[MULT_W-1:0];
        shift_d   = shift_full[SHIFT_W-1:0];
        add_d     = ~dneg_q & m[WIDTH-1];
        sub_d     = dneg_q & ~m[WIDTH-1] & (m != '0);
        inv_out_d = 1'b0;
      end
    end
    out_valid_d = ctrl.final_en | (out_valid_q & ~out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mult_q    <= mult_d;
    shift_q   <= shift_d;
    add_q     <= add_d;
    sub_q     <= sub_d;
    inv_out_q <= inv_out_d;
  end

  sdm_fsm #(.WIDTH(WIDTH), .IW(IW)) u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .ad_small_i  (ad_small),
    .loop_more_i (loop_more),
    .out_free_i  (out_free),
    .ctrl_o      (ctrl),
    .iter_o      (iter)
  );

  assign in_ready_o   = ctrl.idle;
  assign out_valid_o  = out_valid_q;
  assign multiplier_o = mult_q;
  assign shift_amt_o  = shift_q;
  assign add_fix_o    = add_q;
  assign sub_fix_o    = sub_q;
  assign invalid_o    = inv_out_q;

  a_busy_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("sequencer took a second divisor while busy");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(ctrl.final_en))
    else $error("result appeared without a finish cycle");

  a_step_nonzero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.step_en |-> (st_div != '0))
    else $error("divide step run with a zero divisor");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && invalid_o) |->
      (multiplier_o == '0 && shift_amt_o == '0 && !add_fix_o && !sub_fix_o))
    else $error("invalid result carries non-zero fields");

endmodule
